// ===== rtl/core/dcpu_pkg.sv =====
// ---------------------------------------------------------------------------
// Decimal CPU package
// Shared types, status codes, opcodes and decode constants of the decimal
// CPU instruction step unit.
// ---------------------------------------------------------------------------
package dcpu_pkg;

    // Field widths of the channels.
    localparam int PC_W   = 7;
    localparam int WORD_W = 16;
    localparam int LOAD_W = 15;
    localparam int CHAR_W = 7;
    localparam int OUTC_W = 8;
    localparam int OP_W   = 6;
    localparam int RD_W   = 4;
    localparam int Q100_W = 9;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_EXEC = 3'd0,
        ST_HALT = 3'd1,
        ST_IDLE = 3'd2,
        ST_END  = 3'd3,
        ST_BAD  = 3'd4,
        ST_LOAD = 3'd5
    } t_status;

    // Opcodes, taken from the magnitude of the word divided by 1000.
    localparam logic [OP_W-1:0] OP_HALT = 6'd0;
    localparam logic [OP_W-1:0] OP_LD   = 6'd1;
    localparam logic [OP_W-1:0] OP_ST   = 6'd2;
    localparam logic [OP_W-1:0] OP_ADD  = 6'd3;
    localparam logic [OP_W-1:0] OP_NEG  = 6'd4;
    localparam logic [OP_W-1:0] OP_LDM  = 6'd5;
    localparam logic [OP_W-1:0] OP_ADDM = 6'd6;
    localparam logic [OP_W-1:0] OP_BR   = 6'd7;
    localparam logic [OP_W-1:0] OP_BRC  = 6'd8;
    localparam logic [OP_W-1:0] OP_IO   = 6'd9;

    // Register digit selects the I/O operation.
    localparam logic [RD_W-1:0] IO_GETC = 4'd0;
    localparam logic [RD_W-1:0] IO_OUT  = 4'd1;

    // Reciprocal constants: floor(n/100) and floor(n/1000) for n <= 32768.
    localparam logic [31:0] DIV100_MUL  = 32'd41944;
    localparam int          DIV100_SHR  = 22;
    localparam logic [31:0] DIV1000_MUL = 32'd33555;
    localparam int          DIV1000_SHR = 25;
    localparam logic [Q100_W-1:0] DEC_TEN   = 9'd10;
    localparam logic [WORD_W-1:0] DEC_HUNDRED = 16'd100;

    // Request to the main memory.
    typedef struct packed {
        logic              en;
        logic              we;
        logic [PC_W-1:0]   addr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

endpackage

// ===== rtl/core/dcpu_if.sv =====
// ---------------------------------------------------------------------------
// Decimal CPU channels
// Valid/ready channels for the item input and the result output.
// ---------------------------------------------------------------------------
interface dcpu_in_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [6:0]        load_address;
    logic signed [14:0] load_value;
    logic [6:0]        typed_char;

    modport source (output valid, kind, load_address, load_value, typed_char,
                    input ready);
    modport sink   (input valid, kind, load_address, load_value, typed_char,
                    output ready);
endinterface

interface dcpu_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [6:0]         next_pc;
    logic signed [15:0] fetched_word;
    logic               char_valid;
    logic [7:0]         out_char;
    logic               is_running;

    modport source (output valid, status, next_pc, fetched_word, char_valid,
                    out_char, is_running, input ready);
    modport sink   (input valid, status, next_pc, fetched_word, char_valid,
                    out_char, is_running, output ready);
endinterface

// ===== rtl/core/dcpu_mem.sv =====
// ---------------------------------------------------------------------------
// Decimal CPU main memory
// Single-port word memory with registered read data. Per-word valid bits,
// cleared by reset, make unwritten words read as zero. Accesses beyond the
// memory read zero and drop writes.
// ---------------------------------------------------------------------------
module dcpu_mem #(
    parameter int WORDS = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dcpu_pkg::t_mem_req                  i_req,
    output logic [dcpu_pkg::WORD_W-1:0]         o_rdata
);
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [dcpu_pkg::WORD_W-1:0] r_mem [WORDS];
    logic [WORDS-1:0]            r_valid;
    logic [dcpu_pkg::WORD_W-1:0] r_rdata;
    logic                        r_rvalid;
    logic                        w_in_range;
    logic [AW-1:0]               w_idx;

    assign w_in_range = i_req.addr < dcpu_pkg::PC_W'(WORDS);
    assign w_idx      = i_req.addr[AW-1:0];

    // Storage array and read data.
    always_ff @(posedge i_clk) begin
        if (i_req.en && i_req.we && w_in_range) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    // Valid bits and the valid flag of the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.en && i_req.we && w_in_range) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (i_req.en && !i_req.we) begin
                r_rvalid <= w_in_range && r_valid[w_idx];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== rtl/core/decimal_cpu_instruction_step_unit.sv =====
// ---------------------------------------------------------------------------
// Decimal CPU instruction step unit
// Small decimal computer core executing one instruction per step beat.
// ---------------------------------------------------------------------------
// Usage:
// i_in carries items. A load beat (kind 0) writes load_value into main
// memory at load_address. A step beat (kind 1) fetches, decodes and runs
// one instruction; typed_char feeds GETC.
// o_out returns exactly one result beat per input beat, in order: status,
// next program counter, fetched word, an optional character and the run
// flag.
// Each step goes through the single-port main memory: fetch, a two-stage
// decimal decode (reciprocal multiplies), then execute. LD and ADD with an
// operand address inside memory add an operand read after execute; a load
// beat or a step that fetches nothing finishes in the idle state.
// A one-beat input buffer takes the next beat while the core works, and
// the output register holds a result while the receiver stalls; the core
// itself waits only when a finished result cannot be handed on.
// Reset clears memory (through valid bits), registers and the program
// counter, and sets the run flag.
// ---------------------------------------------------------------------------
module decimal_cpu_instruction_step_unit #(
    parameter int MEM_WORDS = 100,
    parameter int NUM_REGS  = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcpu_in_if.sink           i_in,
    dcpu_out_if.source        o_out
);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DEC,
        S_EXEC,
        S_OPND
    } t_state;

    t_state                          r_state;

    // Input buffer.
    logic                            r_in_full;
    logic                            r_in_kind;
    logic [dcpu_pkg::PC_W-1:0]       r_in_addr;
    logic [dcpu_pkg::LOAD_W-1:0]     r_in_value;
    logic [dcpu_pkg::CHAR_W-1:0]     r_in_char;

    // Architectural state.
    logic [dcpu_pkg::PC_W-1:0]       r_pc;
    logic                            r_run;
    logic [dcpu_pkg::WORD_W-1:0]     r_ir;
    logic [dcpu_pkg::WORD_W-1:0]     r_regs [NUM_REGS];

    // Decode pipeline.
    logic [dcpu_pkg::CHAR_W-1:0]     r_char;
    logic                            r_neg;
    logic [dcpu_pkg::WORD_W-1:0]     r_abs;
    logic [dcpu_pkg::OP_W-1:0]       r_q1000;
    logic [dcpu_pkg::Q100_W-1:0]     r_q100;
    logic [dcpu_pkg::OP_W-1:0]       r_op;
    logic [dcpu_pkg::RD_W-1:0]       r_rd;
    logic [dcpu_pkg::PC_W-1:0]       r_amm;

    // Finished result waiting for the output register.
    logic                            r_pend;
    dcpu_pkg::t_status               r_res_status;
    logic [dcpu_pkg::WORD_W-1:0]     r_res_word;
    logic                            r_res_cv;
    logic [dcpu_pkg::OUTC_W-1:0]     r_res_char;

    // Output register.
    logic                            r_out_valid;
    dcpu_pkg::t_status               r_out_status;
    logic [dcpu_pkg::PC_W-1:0]       r_out_pc;
    logic [dcpu_pkg::WORD_W-1:0]     r_out_word;
    logic                            r_out_cv;
    logic [dcpu_pkg::OUTC_W-1:0]     r_out_char;
    logic                            r_out_run;

    logic                            w_push;
    logic                            w_take;
    logic                            w_accept;
    logic                            w_done;
    logic                            w_opnd;
    logic                            w_out_op;
    logic                            w_pc_ok;
    logic                            w_amm_ok;
    logic [dcpu_pkg::WORD_W-1:0]     w_word;
    logic [dcpu_pkg::WORD_W-1:0]     w_rv;
    logic [RW-1:0]                   w_ridx;
    logic [dcpu_pkg::WORD_W-1:0]     w_amm16;
    logic [dcpu_pkg::WORD_W-1:0]     w_mm16;
    logic                            w_br_taken;
    logic [31:0]                     w_prod100;
    logic [31:0]                     w_prod1000;
    logic [dcpu_pkg::Q100_W-1:0]     w_rd9;
    logic [dcpu_pkg::WORD_W-1:0]     w_rem16;
    dcpu_pkg::t_mem_req              w_mem_req;

    // Handshake control.
    assign w_push   = r_pend && (!r_out_valid || o_out.ready);
    assign w_take   = (r_state == S_IDLE) && r_in_full && (!r_pend || w_push);
    assign i_in.ready = !r_in_full || w_take;
    assign w_accept = i_in.valid && i_in.ready;

    // Operand and decode helpers.
    assign w_pc_ok    = r_pc < dcpu_pkg::PC_W'(MEM_WORDS);
    assign w_amm_ok   = r_amm < dcpu_pkg::PC_W'(MEM_WORDS);
    assign w_ridx     = RW'(r_rd);
    assign w_rv       = r_regs[w_ridx];
    assign w_amm16    = {{(dcpu_pkg::WORD_W-dcpu_pkg::PC_W){1'b0}}, r_amm};
    assign w_mm16     = r_neg ? (16'd0 - w_amm16) : w_amm16;
    assign w_br_taken = r_neg ? (w_rv[15] || (w_rv == '0)) : !w_rv[15];
    assign w_prod100  = {16'd0, r_abs} * dcpu_pkg::DIV100_MUL;
    assign w_prod1000 = {16'd0, r_abs} * dcpu_pkg::DIV1000_MUL;
    assign w_rd9      = r_q100 - dcpu_pkg::Q100_W'(r_q1000) * dcpu_pkg::DEC_TEN;
    assign w_rem16    = r_abs - dcpu_pkg::WORD_W'(r_q100) * dcpu_pkg::DEC_HUNDRED;

    // Item completion: LD and ADD with an operand in memory finish in the operand state.
    assign w_opnd   = (r_op == dcpu_pkg::OP_LD || r_op == dcpu_pkg::OP_ADD) && w_amm_ok;
    assign w_out_op = (r_op == dcpu_pkg::OP_IO) && (r_rd == dcpu_pkg::IO_OUT);
    assign w_done   = ((r_state == S_IDLE) && w_take && (!r_in_kind || !r_run || !w_pc_ok))
                   || ((r_state == S_EXEC) && !w_opnd)
                   || (r_state == S_OPND);

    // Memory requests: loads, instruction fetch and operand access.
    always_comb begin
        w_mem_req       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (!r_in_kind) begin
                        w_mem_req.en    = 1'b1;
                        w_mem_req.we    = 1'b1;
                        w_mem_req.addr  = r_in_addr;
                        w_mem_req.wdata = {r_in_value[dcpu_pkg::LOAD_W-1], r_in_value};
                    end else if (r_run && w_pc_ok) begin
                        w_mem_req.en   = 1'b1;
                        w_mem_req.addr = r_pc;
                    end
                end
            end
            S_EXEC: begin
                if (w_opnd) begin
                    w_mem_req.en   = 1'b1;
                    w_mem_req.addr = r_amm;
                end else if (r_op == dcpu_pkg::OP_ST) begin
                    w_mem_req.en    = 1'b1;
                    w_mem_req.we    = 1'b1;
                    w_mem_req.addr  = r_amm;
                    w_mem_req.wdata = w_rv;
                end
            end
            default: begin
                w_mem_req = '0;
            end
        endcase
    end

    dcpu_mem #(
        .WORDS   (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_word)
    );

    // Sequencer, register file, input buffer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_full   <= 1'b0;
            r_pc        <= '0;
            r_run       <= 1'b1;
            r_ir        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            // Input buffer takes a beat whenever it is free or being emptied.
            if (w_accept) begin
                r_in_full  <= 1'b1;
                r_in_kind  <= i_in.kind;
                r_in_addr  <= i_in.load_address;
                r_in_value <= i_in.load_value;
                r_in_char  <= i_in.typed_char;
            end else if (w_take) begin
                r_in_full <= 1'b0;
            end

            // Pending result: set when an item finishes, cleared when handed on.
            if (w_done) begin
                r_pend <= 1'b1;
            end else if (w_push) begin
                r_pend <= 1'b0;
            end

            // Output register.
            if (w_push) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_pc     <= r_pc;
                r_out_word   <= r_res_word;
                r_out_cv     <= r_res_cv;
                r_out_char   <= r_res_char;
                r_out_run    <= r_run;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_char     <= r_in_char;
                        r_res_word <= '0;
                        r_res_cv   <= 1'b0;
                        r_res_char <= '0;
                        if (!r_in_kind) begin
                            r_res_status <= dcpu_pkg::ST_LOAD;
                        end else if (!r_run) begin
                            r_res_status <= dcpu_pkg::ST_IDLE;
                        end else if (!w_pc_ok) begin
                            r_run        <= 1'b0;
                            r_res_status <= dcpu_pkg::ST_END;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    // Word arrives; keep sign and magnitude, advance the counter.
                    r_ir    <= w_word;
                    r_neg   <= w_word[15];
                    r_abs   <= w_word[15] ? (16'd0 - w_word) : w_word;
                    r_pc    <= r_pc + 7'd1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_q1000 <= w_prod1000[dcpu_pkg::DIV1000_SHR +: dcpu_pkg::OP_W];
                    r_q100  <= w_prod100[dcpu_pkg::DIV100_SHR +: dcpu_pkg::Q100_W];
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_op    <= r_q1000;
                    r_rd    <= w_rd9[dcpu_pkg::RD_W-1:0];
                    r_amm   <= w_rem16[dcpu_pkg::PC_W-1:0];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // Result fields of the executed word.
                    r_res_word <= r_ir;
                    r_res_cv   <= w_out_op;
                    r_res_char <= w_out_op ? r_regs[0][dcpu_pkg::OUTC_W-1:0] : '0;
                    r_state    <= w_opnd ? S_OPND : S_IDLE;
                    if (r_op == dcpu_pkg::OP_HALT) begin
                        r_res_status <= dcpu_pkg::ST_HALT;
                    end else if (r_op > dcpu_pkg::OP_IO) begin
                        r_res_status <= dcpu_pkg::ST_BAD;
                    end else begin
                        r_res_status <= dcpu_pkg::ST_EXEC;
                    end
                    // Register, counter and run flag updates.
                    case (r_op)
                        dcpu_pkg::OP_HALT: begin
                            r_run <= 1'b0;
                        end
                        dcpu_pkg::OP_LD: begin
                            if (!w_amm_ok) begin
                                r_regs[w_ridx] <= '0;
                            end
                        end
                        dcpu_pkg::OP_NEG: begin
                            r_regs[w_ridx] <= 16'd0 - w_rv;
                        end
                        dcpu_pkg::OP_LDM: begin
                            r_regs[w_ridx] <= w_mm16;
                        end
                        dcpu_pkg::OP_ADDM: begin
                            r_regs[w_ridx] <= r_neg ? (w_rv - w_amm16) : (w_rv + w_amm16);
                        end
                        dcpu_pkg::OP_BR: begin
                            r_pc <= r_amm;
                        end
                        dcpu_pkg::OP_BRC: begin
                            if (w_br_taken) begin
                                r_pc <= r_amm;
                            end
                        end
                        dcpu_pkg::OP_IO: begin
                            if (r_rd == dcpu_pkg::IO_GETC) begin
                                r_regs[0] <= {{(dcpu_pkg::WORD_W-dcpu_pkg::CHAR_W){1'b0}}, r_char};
                            end
                        end
                        default: begin
                            // ST goes through memory; ADD and bad opcodes change nothing here.
                        end
                    endcase
                end
                S_OPND: begin
                    // Operand word arrives for LD or ADD.
                    if (r_op == dcpu_pkg::OP_LD) begin
                        r_regs[w_ridx] <= w_word;
                    end else begin
                        r_regs[w_ridx] <= w_rv + w_word;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output channel.
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.next_pc      = r_out_pc;
    assign o_out.fetched_word = r_out_word;
    assign o_out.char_valid   = r_out_cv;
    assign o_out.out_char     = r_out_char;
    assign o_out.is_running   = r_out_run;

endmodule

// ===== rtl/core/dcpu_chk.sv =====
// ---------------------------------------------------------------------------
// Decimal CPU port checker
// Concurrent checks on the result channel of the instruction step unit,
// attached to the top level by a bind statement.
// ---------------------------------------------------------------------------
module dcpu_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [6:0]  i_next_pc,
    input  logic [15:0] i_fetched_word,
    input  logic        i_char_valid,
    input  logic [7:0]  i_out_char,
    input  logic        i_is_running
);

    // A stalled result beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_status, i_next_pc, i_fetched_word, i_char_valid, i_out_char,
                 i_is_running}))
        else $error("result beat dropped or changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // Halt, end of memory and a stopped core all report the run flag low.
    a_stop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == dcpu_pkg::ST_HALT ||
                        i_status == dcpu_pkg::ST_IDLE ||
                        i_status == dcpu_pkg::ST_END) |-> !i_is_running)
        else $error("stopped status with run flag set");

    // A character only comes from an executed instruction.
    a_char_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char_valid |-> i_status == dcpu_pkg::ST_EXEC)
        else $error("character with a non-executed status");

endmodule

bind decimal_cpu_instruction_step_unit dcpu_chk u_dcpu_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_next_pc      (o_out.next_pc),
    .i_fetched_word (o_out.fetched_word),
    .i_char_valid   (o_out.char_valid),
    .i_out_char     (o_out.out_char),
    .i_is_running   (o_out.is_running)
);
